@@ design/sbl_pkg.sv @@
// shared types, constants and arithmetic helpers of the separable blur line buffer
package sbl_pkg;

  // tile geometry and channel count
  localparam int TILE_W   = 256;
  localparam int TILE_H   = 256;
  localparam int CHANNELS = 3;
  localparam int NCH      = (CHANNELS < 3) ? CHANNELS : 3;

  // input tile, with a four-column and two-row margin
  localparam int IN_W = TILE_W + 4;
  localparam int IN_H = TILE_H + 2;

  localparam int CH_MAX  = 3;
  localparam int PIX_W   = 8;
  localparam int PROD_W  = 2 * PIX_W;
  localparam int HTAPS   = 5;
  localparam int VTAPS   = 3;
  localparam int WIN_LEN = HTAPS - 1;

  localparam int COL_W = $clog2(IN_W);
  localparam int ROW_W = $clog2(IN_H);

  // line memory: one entry per input column
  localparam int MEM_DEPTH = IN_W;
  localparam int ADDR_W    = COL_W;

  // configuration port
  localparam int HW_W       = HTAPS * PIX_W;
  localparam int VW_W       = VTAPS * PIX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HW_W;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_BLUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_WEIGHTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_WEIGHTS   = 2'd2;

  typedef logic [PIX_W-1:0] chan_t;
  typedef chan_t [CH_MAX-1:0] pix_t;

  typedef struct packed {
    logic            enable_blur;
    logic [HW_W-1:0] horizontal_weights;
    logic [VW_W-1:0] vertical_weights;
  } cfg_t;

  // one line memory entry: raw and horizontal values of the two rows above
  typedef struct packed {
    pix_t raw_r1;
    pix_t raw_r2;
    pix_t hb_r1;
    pix_t hb_r2;
  } line_word_t;

  localparam int MEM_W = $bits(line_word_t);

  // low byte of an 8x8 product
  function automatic chan_t mul_lo(input chan_t a, input chan_t b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return p[PIX_W-1:0];
  endfunction

  // floor(x / 5) for 8-bit x, reciprocal 205/1024
  function automatic chan_t div5(input chan_t x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(205);
    return PIX_W'(p[PROD_W-1:10]);
  endfunction

  // floor(x / 3) for 8-bit x, reciprocal 171/512
  function automatic chan_t div3(input chan_t x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(171);
    return PIX_W'(p[PROD_W-1:9]);
  endfunction

endpackage

@@ design/sbl_pix_in_if.sv @@
// input pixel stream channel
interface sbl_pix_in_if;
  logic                     valid;
  logic                     ready;
  logic [sbl_pkg::PIX_W-1:0] pixel_c0;
  logic [sbl_pkg::PIX_W-1:0] pixel_c1;
  logic [sbl_pkg::PIX_W-1:0] pixel_c2;

  modport source (output valid, output pixel_c0, output pixel_c1, output pixel_c2,
                  input ready);
  modport sink (input valid, input pixel_c0, input pixel_c1, input pixel_c2,
                output ready);
endinterface

@@ design/sbl_pix_out_if.sv @@
// output pixel stream channel
interface sbl_pix_out_if;
  logic                     valid;
  logic                     ready;
  logic [sbl_pkg::PIX_W-1:0] out_c0;
  logic [sbl_pkg::PIX_W-1:0] out_c1;
  logic [sbl_pkg::PIX_W-1:0] out_c2;
  logic                     out_last;

  modport source (output valid, output out_c0, output out_c1, output out_c2,
                  output out_last, input ready);
  modport sink (input valid, input out_c0, input out_c1, input out_c2,
                input out_last, output ready);
endinterface

@@ design/sbl_cfg_if.sv @@
// configuration write channel
interface sbl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sbl_pkg::CFG_IDX_W-1:0]  index;
  logic [sbl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/separable_blur_linebuffer.sv @@
// top level: separable weighted 5x3 blur over a streamed tile
//
//   channel   dir  beat                                   modport
//   cfg       in   register index + write data            sbl_cfg_if.sink
//   pix_in    in   pixel_c0..pixel_c2, raster order       sbl_pix_in_if.sink
//   pix_out   out  out_c0..out_c2, out_last               sbl_pix_out_if.source
//
// one input beat per cycle sustained while the output is taken; a result passes to the output
// register through the stage chain: window products, line memory read + divide by 5,
// vertical sum, divide by 3 into the output register
// the line memory is read once and written once per beat (read-modify-write of
// the entry of the current column); the same entry comes back only a whole row later
// rst clears counters, window, stage valids and registers; the memory needs no clearing
// each stage moves when the one after it is empty or moving, so bubbles soak up stalls
module separable_blur_linebuffer (
  input  logic          clk,
  input  logic          rst,
  sbl_cfg_if.sink       cfg,
  sbl_pix_in_if.sink    pix_in,
  sbl_pix_out_if.source pix_out
);

  sbl_pkg::cfg_t regs;

  sbl_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // position of the next input pixel
  logic [sbl_pkg::COL_W-1:0] col;
  logic [sbl_pkg::ROW_W-1:0] row;

  // last four input pixels, runs on across rows
  sbl_pkg::pix_t win [sbl_pkg::WIN_LEN];
  sbl_pkg::pix_t in_px;

  // stage enables
  logic en1, en2, en3, en4;
  logic in_acc;

  // stage 1: weighted horizontal products, memory read in flight
  logic                      s1_v;
  logic                      s1_emit;
  logic                      s1_last;
  logic [sbl_pkg::COL_W-1:0] s1_col;
  sbl_pkg::pix_t             s1_w0;
  sbl_pkg::chan_t            s1_hp [sbl_pkg::CH_MAX][sbl_pkg::HTAPS];

  // stage 2: horizontal value and the two upper-row vertical products
  logic           s2_v;
  logic           s2_emit;
  logic           s2_last;
  sbl_pkg::pix_t  s2_hb;
  sbl_pkg::pix_t  s2_vp0;
  sbl_pkg::pix_t  s2_vp1;
  sbl_pkg::pix_t  s2_raw;

  // stage 3: vertical sum, wrapped to 8 bits
  logic           s3_v;
  logic           s3_emit;
  logic           s3_last;
  sbl_pkg::pix_t  s3_vsum;
  sbl_pkg::pix_t  s3_raw;

  // output register
  logic           out_valid;
  logic           out_last;
  sbl_pkg::pix_t  out_px;

  // line memory ports
  logic [sbl_pkg::MEM_W-1:0] rd_data;
  logic [sbl_pkg::MEM_W-1:0] wr_data;
  logic                      wr_en;
  sbl_pkg::line_word_t       rd_word;
  sbl_pkg::line_word_t       wr_word;
  sbl_pkg::pix_t             hb_new;
  sbl_pkg::chan_t            hsum [sbl_pkg::CH_MAX];

  logic in_emit;
  logic in_last;

  assign in_px[0] = pix_in.pixel_c0;
  assign in_px[1] = pix_in.pixel_c1;
  assign in_px[2] = pix_in.pixel_c2;

  // handshake chain, back to front
  assign en4 = !out_valid || pix_out.ready;
  assign en3 = !s3_v || en4;
  assign en2 = !s2_v || en3;
  assign en1 = !s1_v || en2;

  assign pix_in.ready = en1;
  assign in_acc       = pix_in.valid && en1;

  // results only once a full 5x3 neighborhood has arrived
  assign in_emit = (col >= sbl_pkg::COL_W'(sbl_pkg::WIN_LEN))
                && (row >= sbl_pkg::ROW_W'(sbl_pkg::VTAPS - 1));
  assign in_last = (col == sbl_pkg::COL_W'(sbl_pkg::IN_W - 1))
                && (row == sbl_pkg::ROW_W'(sbl_pkg::IN_H - 1));

  // position counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      for (int k = 0; k < sbl_pkg::WIN_LEN; k++) begin
        win[k] <= '0;
      end
    end else if (in_acc) begin
      for (int k = 0; k < sbl_pkg::WIN_LEN - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[sbl_pkg::WIN_LEN-1] <= in_px;
      if (col == sbl_pkg::COL_W'(sbl_pkg::IN_W - 1)) begin
        col <= '0;
        if (row == sbl_pkg::ROW_W'(sbl_pkg::IN_H - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // stage 1: tap products; the memory entry of this column is read at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col  <= col;
      s1_emit <= in_emit;
      s1_last <= in_last;
      s1_w0   <= win[0];
      for (int c = 0; c < sbl_pkg::CH_MAX; c++) begin
        for (int k = 0; k < sbl_pkg::WIN_LEN; k++) begin
          s1_hp[c][k] <= sbl_pkg::mul_lo(win[k][c],
                                         regs.horizontal_weights[8*k +: sbl_pkg::PIX_W]);
        end
        s1_hp[c][sbl_pkg::WIN_LEN] <= sbl_pkg::mul_lo(in_px[c],
            regs.horizontal_weights[8*sbl_pkg::WIN_LEN +: sbl_pkg::PIX_W]);
      end
    end
  end

  // horizontal sum wraps to 8 bits, then divide by 5
  always_comb begin
    for (int c = 0; c < sbl_pkg::CH_MAX; c++) begin
      hsum[c] = s1_hp[c][0] + s1_hp[c][1] + s1_hp[c][2] + s1_hp[c][3] + s1_hp[c][4];
      hb_new[c] = sbl_pkg::div5(hsum[c]);
    end
  end

  // entry shifts down one row: new values become "one row up" for the next visit
  assign rd_word        = sbl_pkg::line_word_t'(rd_data);
  assign wr_word.raw_r1 = s1_w0;
  assign wr_word.raw_r2 = rd_word.raw_r1;
  assign wr_word.hb_r1  = hb_new;
  assign wr_word.hb_r2  = rd_word.hb_r1;
  assign wr_data        = wr_word;
  assign wr_en          = s1_v && en2;

  sbl_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v) begin
      s2_emit <= s1_emit;
      s2_last <= s1_last;
      s2_hb   <= hb_new;
      s2_raw  <= rd_word.raw_r2;
      for (int c = 0; c < sbl_pkg::CH_MAX; c++) begin
        s2_vp0[c] <= sbl_pkg::mul_lo(rd_word.hb_r2[c],
                                     regs.vertical_weights[0 +: sbl_pkg::PIX_W]);
        s2_vp1[c] <= sbl_pkg::mul_lo(rd_word.hb_r1[c],
                                     regs.vertical_weights[8 +: sbl_pkg::PIX_W]);
      end
    end
  end

  // stage 3: current-row product joins the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_v) begin
      s3_emit <= s2_emit;
      s3_last <= s2_last;
      s3_raw  <= s2_raw;
      for (int c = 0; c < sbl_pkg::CH_MAX; c++) begin
        s3_vsum[c] <= s2_vp0[c] + s2_vp1[c]
                    + sbl_pkg::mul_lo(s2_hb[c], regs.vertical_weights[16 +: sbl_pkg::PIX_W]);
      end
    end
  end

  // output register: divide by 3 or pass the delayed raw pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= s3_v && s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_v) begin
      out_last <= s3_last;
      for (int c = 0; c < sbl_pkg::CH_MAX; c++) begin
        if (c < sbl_pkg::NCH) begin
          out_px[c] <= regs.enable_blur ? sbl_pkg::div3(s3_vsum[c]) : s3_raw[c];
        end else begin
          out_px[c] <= '0;
        end
      end
    end
  end

  assign pix_out.valid    = out_valid;
  assign pix_out.out_c0   = out_px[0];
  assign pix_out.out_c1   = out_px[1];
  assign pix_out.out_c2   = out_px[2];
  assign pix_out.out_last = out_last;

  // column counter wraps at the end of an input row
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && col == sbl_pkg::COL_W'(sbl_pkg::IN_W - 1)) |=> (col == '0))
    else $error("column counter did not wrap");

  // warm-up columns enter the pipe but never produce a result
  a_warmup: assert property (@(posedge clk) disable iff (rst)
    (in_acc && col < sbl_pkg::COL_W'(sbl_pkg::WIN_LEN)) |=> (s1_v && !s1_emit))
    else $error("warm-up column marked as producing a result");

  // a blocked stage 2 item keeps its horizontal value
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_v && !en3) |=> (s2_v && $stable(s2_hb)))
    else $error("stalled stage 2 item changed");

  // a result item moving into a free output register shows up
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    (s3_v && s3_emit && en4) |=> out_valid)
    else $error("result item lost at the output register");

endmodule

@@ design/sbl_cfg_regs.sv @@
// configuration registers of the blur block
module sbl_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  sbl_cfg_if.sink          cfg,
  output sbl_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable_blur        <= 1'b1;
      regs.horizontal_weights <= '0;
      regs.vertical_weights   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sbl_pkg::REG_ENABLE_BLUR: regs.enable_blur <= cfg.data[0];
        sbl_pkg::REG_H_WEIGHTS: regs.horizontal_weights <= cfg.data[sbl_pkg::HW_W-1:0];
        sbl_pkg::REG_V_WEIGHTS: regs.vertical_weights <= cfg.data[sbl_pkg::VW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/sbl_line_mem.sv @@
// line memory, one write and one registered read port
module sbl_line_mem (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [sbl_pkg::ADDR_W-1:0] rd_addr,
  output logic [sbl_pkg::MEM_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [sbl_pkg::ADDR_W-1:0] wr_addr,
  input  logic [sbl_pkg::MEM_W-1:0]  wr_data
);

  logic [sbl_pkg::MEM_W-1:0] mem [sbl_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ test/tb_top.sv @@
// testbench of the separable blur line buffer: tile stream against a bit-exact blur predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // clock, reset and run length
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // settle time after the owed beats are out, longer than a result's trip through the pipe
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 10_000;
  localparam int IDLE_PCT      = 38;
  localparam int HOLD_CYCLES   = 500;

  // random part: runs on into the rows that give results, new register setting per phase
  localparam int PHASE_ITEMS  = 80;
  localparam int RANDOM_ITEMS = 12 * PHASE_ITEMS;
  localparam int HOLD_AT      = 20;
  localparam int SETTINGS_N   = 6;
  localparam int STEADY_PHASE = 3;
  localparam int HOLD_PHASE   = 5;

  // register index that maps to no register
  localparam logic [sbl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  // one row of the directed table: a pixel beat or a register write
  typedef struct packed {
    row_kind_t                      kind;
    logic [sbl_pkg::CFG_IDX_W-1:0]  idx;
    logic [sbl_pkg::CFG_DATA_W-1:0] data;
    sbl_pkg::pix_t                  pix;
    logic                           quiet;   // typed in: this beat must cause no output
  } dir_row_t;

  // one output beat
  typedef struct packed {
    sbl_pkg::chan_t ch0;
    sbl_pkg::chan_t ch1;
    sbl_pkg::chan_t ch2;
    logic           last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbl_cfg_if     cfg_ch ();
  sbl_pix_in_if  pin ();
  sbl_pix_out_if pout ();

  separable_blur_linebuffer dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pix_in  (pin),
    .pix_out (pout)
  );

  always #(CLK_HALF) clk = ~clk;

  // blur predictor state: position, window, line stores and registers
  int unsigned   col_pos = 0;
  int unsigned   row_pos = 0;
  sbl_pkg::pix_t win      [sbl_pkg::WIN_LEN];
  sbl_pkg::pix_t hb_rows  [2*sbl_pkg::TILE_W];
  sbl_pkg::pix_t raw_rows [2*sbl_pkg::IN_W];
  logic                     blur_on = 1'b1;
  logic [sbl_pkg::HW_W-1:0] h_taps  = '0;
  logic [sbl_pkg::VW_W-1:0] v_taps  = '0;

  // output beats still owed by the block, oldest first
  out_beat_t pending_pixels [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic        steady      = 1'b0;   // no idling on either side
  logic        hold_rx     = 1'b0;   // receiver held off
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;

  dir_row_t dir_rows [25];

  function automatic dir_row_t px(input sbl_pkg::chan_t c0, input sbl_pkg::chan_t c1,
                                  input sbl_pkg::chan_t c2);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_PIX;
    r.pix   = {c2, c1, c0};
    r.quiet = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t wr(input logic [sbl_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sbl_pkg::CFG_DATA_W-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // advance the predictor by one accepted input beat; returns 1 when it yields an output
  function automatic bit blur_pixel_step(input sbl_pkg::pix_t p, output out_beat_t beat);
    int unsigned rp, x, qc, qo;
    int          c, k;
    logic        emit;
    sbl_pkg::pix_t  raw_old, res, o;
    sbl_pkg::chan_t a, s, hb, v;
    logic [2*sbl_pkg::PIX_W-1:0] prod;
    rp   = (row_pos % 2) * sbl_pkg::IN_W + col_pos;
    emit = (col_pos >= sbl_pkg::WIN_LEN) && (row_pos >= 2);
    res  = '0;
    // raw delay line: read two rows back, then store the pixel leaving the window
    raw_old      = raw_rows[rp];
    raw_rows[rp] = win[0];
    if (col_pos >= sbl_pkg::WIN_LEN) begin
      x  = col_pos - sbl_pkg::WIN_LEN;
      qc = (row_pos % 2) * sbl_pkg::TILE_W + x;
      qo = ((row_pos + 1) % 2) * sbl_pkg::TILE_W + x;
      for (c = 0; c < sbl_pkg::NCH; c++) begin
        // horizontal taps, every product and sum wrapped to 8 bits
        s = 8'h00;
        for (k = 0; k < sbl_pkg::HTAPS; k++) begin
          if (k < sbl_pkg::WIN_LEN) a = win[k][c];
          else a = p[c];
          prod = a * h_taps[8*k +: 8];
          s    = s + prod[sbl_pkg::PIX_W-1:0];
        end
        hb = s / 8'd5;
        if (emit) begin
          v    = 8'h00;
          prod = hb_rows[qc][c] * v_taps[7:0];
          v    = v + prod[sbl_pkg::PIX_W-1:0];
          prod = hb_rows[qo][c] * v_taps[15:8];
          v    = v + prod[sbl_pkg::PIX_W-1:0];
          prod = hb * v_taps[23:16];
          v    = v + prod[sbl_pkg::PIX_W-1:0];
          res[c] = v / 8'd3;
        end
        hb_rows[qc][c] = hb;
      end
    end
    // the window runs on across rows
    for (k = 0; k < sbl_pkg::WIN_LEN - 1; k++) win[k] = win[k+1];
    win[sbl_pkg::WIN_LEN-1] = p;
    col_pos++;
    if (col_pos >= sbl_pkg::IN_W) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= sbl_pkg::IN_H) row_pos = 0;
    end
    // channels above the configured count stay zero
    for (c = 0; c < 3; c++) o[c] = (c < sbl_pkg::NCH) ? (blur_on ? res[c] : raw_old[c]) : '0;
    beat.ch0  = o[0];
    beat.ch1  = o[1];
    beat.ch2  = o[2];
    beat.last = (col_pos == 0) && (row_pos == 0);
    return emit;
  endfunction

  task automatic check_field(input string name, input sbl_pkg::chan_t want,
                             input sbl_pkg::chan_t got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // one register write; the predictor takes it at the handshake, masked to the register width
  task automatic cfg_write(input logic [sbl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbl_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    unique case (idx)
      sbl_pkg::REG_ENABLE_BLUR: blur_on = data[0];
      sbl_pkg::REG_H_WEIGHTS:   h_taps  = data[sbl_pkg::HW_W-1:0];
      sbl_pkg::REG_V_WEIGHTS:   v_taps  = data[sbl_pkg::VW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    @(negedge clk);
  endtask

  // one input beat with random gaps in front; check_it=0 means the row typed in silence
  task automatic send_pixel(input sbl_pkg::pix_t p, input bit check_it);
    out_beat_t beat;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pin.valid = 1'b0;
      @(negedge clk);
    end
    pin.valid    = 1'b1;
    pin.pixel_c0 = p[0];
    pin.pixel_c1 = p[1];
    pin.pixel_c2 = p[2];
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    if (blur_pixel_step(p, beat) && check_it) pending_pixels.push_back(beat);
    @(negedge clk);
  endtask

  // sender pauses until every owed beat is out and the pipe has emptied
  task automatic settle();
    pin.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver: random stalls, none while steady, stalled throughout while held off
  always @(negedge clk) begin
    if (hold_rx) begin
      pout.ready <= 1'b0;
    end else if (steady) begin
      pout.ready <= 1'b1;
    end else begin
      pout.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering beats meanwhile
  initial begin : rx_hold
    forever begin
      wait (holds_asked != holds_done);
      hold_rx = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_rx = 1'b0;
      holds_done++;
    end
  end

  // every accepted output beat against the oldest owed one
  always @(posedge clk) begin : out_check
    out_beat_t want;
    if (!rst && pout.valid && pout.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        $error("output beat with none owed: %0h %0h %0h last %0b",
               pout.out_c0, pout.out_c1, pout.out_c2, pout.out_last);
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_c0", want.ch0, pout.out_c0);
        check_field("out_c1", want.ch1, pout.out_c1);
        check_field("out_c2", want.ch2, pout.out_c2);
        check_field("out_last", {7'b0, want.last}, {7'b0, pout.out_last});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned                    sent, phase, drain, pick;
    int                             c;
    sbl_pkg::pix_t                  p;
    logic                           en;
    logic [sbl_pkg::HW_W-1:0]       hw;
    logic [sbl_pkg::VW_W-1:0]       vw;
    logic [sbl_pkg::CFG_DATA_W-1:0] junk;

    foreach (win[i]) win[i] = '0;
    foreach (hb_rows[i]) hb_rows[i] = '0;
    foreach (raw_rows[i]) raw_rows[i] = '0;
    pin.valid    = 1'b0;
    pin.pixel_c0 = '0;
    pin.pixel_c1 = '0;
    pin.pixel_c2 = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    pout.ready   = 1'b0;

    // directed part: the opening beats of the tile are all warm-up, so none may give output;
    // walking bits and extremes enter the stores, some register writes carry junk above the field
    dir_rows = '{
      px(8'h00, 8'h00, 8'h00),
      px(8'hFF, 8'hFF, 8'hFF),
      px(8'h01, 8'h02, 8'h04),
      px(8'h08, 8'h10, 8'h20),
      wr(sbl_pkg::REG_ENABLE_BLUR, 40'hFF_FFFF_FFFE),
      px(8'h40, 8'h80, 8'h55),
      px(8'hAA, 8'h55, 8'hAA),
      wr(sbl_pkg::REG_H_WEIGHTS, 40'hFF_FFFF_FFFF),
      px(8'hFE, 8'hFD, 8'hFB),
      px(8'hF7, 8'hEF, 8'hDF),
      wr(sbl_pkg::REG_V_WEIGHTS, 40'hFF_FFFF_FFFF),
      px(8'hBF, 8'h7F, 8'h00),
      px(8'h80, 8'h40, 8'h20),
      wr(REG_SPARE, 40'h12_3456_789A),
      px(8'h10, 8'h08, 8'h04),
      px(8'h02, 8'h01, 8'h80),
      wr(sbl_pkg::REG_ENABLE_BLUR, 40'h00_0000_0001),
      wr(sbl_pkg::REG_H_WEIGHTS, 40'h01_0101_0101),
      wr(sbl_pkg::REG_V_WEIGHTS, 40'h00_0001_0101),
      px(8'hFF, 8'h00, 8'hFF),
      px(8'h00, 8'hFF, 8'h00),
      px(8'h55, 8'hAA, 8'h55),
      px(8'h7F, 8'h80, 8'h01),
      px(8'h33, 8'hCC, 8'h0F),
      px(8'hF0, 8'h0F, 8'hFF)
    };

    // synchronous reset, once
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_pixel(dir_rows[i].pix, !dir_rows[i].quiet);
      end
    end

    // random part: on through the warm-up rows into the ones that give results
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % PHASE_ITEMS == 0) begin
        phase = sent / PHASE_ITEMS;
        settle();
        steady = (phase % SETTINGS_N == STEADY_PHASE);
        junk   = sbl_pkg::CFG_DATA_W'({$urandom(), $urandom()});
        hw     = sbl_pkg::HW_W'({$urandom(), $urandom()});
        vw     = sbl_pkg::VW_W'($urandom());
        en     = 1'b1;
        unique case (phase % SETTINGS_N)
          0: begin
            hw = '1;
            vw = '1;
          end
          1: begin
            // plain box weights
            hw = {sbl_pkg::HTAPS{8'h01}};
            vw = {sbl_pkg::VTAPS{8'h01}};
          end
          2: en = 1'b0;   // raw pass-through
          4: vw = '0;
          5: hw = '0;
          default: ;
        endcase
        cfg_write(sbl_pkg::REG_ENABLE_BLUR, {junk[sbl_pkg::CFG_DATA_W-1:1], en});
        cfg_write(sbl_pkg::REG_V_WEIGHTS, {junk[sbl_pkg::CFG_DATA_W-1:sbl_pkg::VW_W], vw});
        cfg_write(sbl_pkg::REG_H_WEIGHTS, hw);
      end
      // receiver stalls long enough for the pipe to fill and push back on the input
      if (sent % PHASE_ITEMS == HOLD_AT && phase % SETTINGS_N == HOLD_PHASE) holds_asked++;
      for (c = 0; c < 3; c++) begin
        pick = $urandom_range(9);
        p[c] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : sbl_pkg::chan_t'($urandom());
      end
      send_pixel(p, 1'b1);
      sent++;
    end
    pin.valid = 1'b0;
    steady    = 1'b0;

    // drain, then settle for any stray beat
    drain = 0;
    while (pending_pixels.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0) begin
      mismatches++;
      $error("%0d owed output beats never came", pending_pixels.size());
    end

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
